@@ design/wsdf_pkg.sv @@
// ----------------------------------------------------------------------------
// wsdf_pkg: shared types and constants for the frame deframer
// Beat structs for both channels, parser phase, frame kind and status codes.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	// header field masks and codes
	localparam logic [7:0] RSV_MASK   = 8'h70;
	localparam logic [7:0] TOP_BIT    = 8'h80;
	localparam logic [7:0] OPC_MASK   = 8'h0f;
	localparam logic [7:0] LEN7_MASK  = 8'h7f;
	localparam logic [6:0] LEN7_LONG  = 7'h7f;
	localparam logic [6:0] LEN7_EXT16 = 7'h7e;

	localparam logic [3:0] OPC_TEXT   = 4'h1;
	localparam logic [3:0] OPC_BINARY = 4'h2;
	localparam logic [3:0] OPC_CLOSE  = 4'h8;
	localparam logic [3:0] OPC_PING   = 4'h9;
	localparam logic [3:0] OPC_PONG   = 4'ha;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_CLOSE = 3'd1;
	localparam logic [2:0] ST_OTHER = 3'd2;
	localparam logic [2:0] ST_BAD   = 3'd3;
	localparam logic [2:0] ST_TRUNC = 3'd4;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_LEN    = 6'b000010,
		PH_EXT_HI = 6'b000100,
		PH_EXT_LO = 6'b001000,
		PH_KEY    = 6'b010000,
		PH_DATA   = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TEXT  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_OTHER = 2'd2,
		KIND_BAD   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_first;
		logic       frame_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       frame_done;
		logic [2:0] status;
	} out_beat_t;

endpackage

@@ design/websocket_frame_deframer_core.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core: byte-wide frame header parser and unmasker
// Parses FIN/RSV/opcode, mask bit, 7- or 16-bit length and the masking key,
// then emits unmasked text payload bytes and a per-frame status.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  frm     | in  | frm_valid/frm_stall  | frm : in_beat_t  (byte, first, last)
//  res     | out | res_valid/res_stall  | res : out_beat_t (byte, flags, status)
//
//  One beat per cycle sustained while res_stall is low. A beat is held in the
//  input register, is parsed and unmasked there in one pass, and lands in the
//  result register, from which its result is offered. The result register
//  sets the pace: while a result waits under res_stall, a beat held in the
//  input register stays there and frm_stall rises. Beats that give no result
//  still pass through the input register.
//  Reset clears the parser state and both valid flags; the masking key is not
//  reset, it is always written before use within a frame.
//
module websocket_frame_deframer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frm_valid,
	output logic                frm_stall,
	input  wsdf_pkg::in_beat_t  frm,
	output logic                res_valid,
	input  logic                res_stall,
	output wsdf_pkg::out_beat_t res
);

	// input register
	logic               valid_s1;
	wsdf_pkg::in_beat_t beat_s1;

	// parser state
	wsdf_pkg::phase_t phase_q, phase_d;
	wsdf_pkg::kind_t  kind_q, kind_d;
	logic [7:0]       len_hi_q, len_hi_d;
	logic [15:0]      remain_q, remain_d;
	logic [1:0]       key_idx_q, key_idx_d;
	logic [7:0]       mask_key_q [4];
	logic             key_we;

	// result register
	logic                res_valid_q;
	wsdf_pkg::out_beat_t res_q;

	logic                res_free;
	logic                advance;
	logic                emit;
	wsdf_pkg::out_beat_t res_d;

	// working values for the beat in the input register
	logic [7:0]       b;
	logic [3:0]       opc;
	logic [6:0]       len7;
	wsdf_pkg::kind_t  kind_b0;
	wsdf_pkg::kind_t  kind_b1;
	logic [15:0]      remain_dec;
	logic [2:0]       trunc_st;

	assign res_free  = !res_valid_q || !res_stall;
	assign advance   = valid_s1 && res_free;
	assign frm_stall = valid_s1 && !res_free;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign b          = beat_s1.in_byte;
	assign opc        = b[3:0] & wsdf_pkg::OPC_MASK[3:0];
	assign len7       = b[6:0] & wsdf_pkg::LEN7_MASK[6:0];
	assign remain_dec = remain_q - 16'd1;
	assign trunc_st   = (kind_q == wsdf_pkg::KIND_BAD) ? wsdf_pkg::ST_BAD : wsdf_pkg::ST_TRUNC;

	// byte 0 classification
	always_comb begin
		if ((b & wsdf_pkg::RSV_MASK) != 8'd0 || (b & wsdf_pkg::TOP_BIT) != wsdf_pkg::TOP_BIT) begin
			kind_b0 = wsdf_pkg::KIND_BAD;
		end else if (opc == wsdf_pkg::OPC_TEXT) begin
			kind_b0 = wsdf_pkg::KIND_TEXT;
		end else if (opc == wsdf_pkg::OPC_CLOSE) begin
			kind_b0 = wsdf_pkg::KIND_CLOSE;
		end else if (opc == wsdf_pkg::OPC_BINARY || opc == wsdf_pkg::OPC_PING
				|| opc == wsdf_pkg::OPC_PONG) begin
			kind_b0 = wsdf_pkg::KIND_OTHER;
		end else begin
			kind_b0 = wsdf_pkg::KIND_BAD;
		end
	end

	// byte 1: mask bit clear or 64-bit length makes the frame malformed
	assign kind_b1 = ((b & wsdf_pkg::TOP_BIT) != wsdf_pkg::TOP_BIT || len7 == wsdf_pkg::LEN7_LONG)
		? wsdf_pkg::KIND_BAD : kind_q;

	// parser step
	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		len_hi_d  = len_hi_q;
		remain_d  = remain_q;
		key_idx_d = key_idx_q;
		key_we    = 1'b0;
		emit      = 1'b0;
		res_d     = '0;

		if (beat_s1.frame_first) begin
			kind_d    = kind_b0;
			len_hi_d  = 8'd0;
			remain_d  = 16'd0;
			key_idx_d = 2'd0;
			if (beat_s1.frame_last) begin
				phase_d          = wsdf_pkg::PH_IDLE;
				emit             = 1'b1;
				res_d.frame_done = 1'b1;
				res_d.status     = (kind_b0 == wsdf_pkg::KIND_BAD)
					? wsdf_pkg::ST_BAD : wsdf_pkg::ST_TRUNC;
			end else begin
				phase_d = wsdf_pkg::PH_LEN;
			end
		end else begin
			unique case (phase_q)
				wsdf_pkg::PH_LEN: begin
					kind_d = kind_b1;
					if (kind_b1 != wsdf_pkg::KIND_TEXT) begin
						phase_d          = wsdf_pkg::PH_IDLE;
						emit             = 1'b1;
						res_d.frame_done = 1'b1;
						unique case (kind_b1)
							wsdf_pkg::KIND_CLOSE: res_d.status = wsdf_pkg::ST_CLOSE;
							wsdf_pkg::KIND_OTHER: res_d.status = wsdf_pkg::ST_OTHER;
							default:              res_d.status = wsdf_pkg::ST_BAD;
						endcase
					end else if (len7 == wsdf_pkg::LEN7_EXT16) begin
						phase_d = wsdf_pkg::PH_EXT_HI;
					end else begin
						remain_d  = {9'd0, len7};
						key_idx_d = 2'd0;
						phase_d   = wsdf_pkg::PH_KEY;
					end
					if (!emit && beat_s1.frame_last) begin
						phase_d          = wsdf_pkg::PH_IDLE;
						emit             = 1'b1;
						res_d.frame_done = 1'b1;
						res_d.status     = wsdf_pkg::ST_TRUNC;
					end
				end
				wsdf_pkg::PH_EXT_HI: begin
					len_hi_d = b;
					phase_d  = wsdf_pkg::PH_EXT_LO;
					if (beat_s1.frame_last) begin
						phase_d          = wsdf_pkg::PH_IDLE;
						emit             = 1'b1;
						res_d.frame_done = 1'b1;
						res_d.status     = trunc_st;
					end
				end
				wsdf_pkg::PH_EXT_LO: begin
					remain_d  = {len_hi_q, b};
					key_idx_d = 2'd0;
					phase_d   = wsdf_pkg::PH_KEY;
					if (beat_s1.frame_last) begin
						phase_d          = wsdf_pkg::PH_IDLE;
						emit             = 1'b1;
						res_d.frame_done = 1'b1;
						res_d.status     = trunc_st;
					end
				end
				wsdf_pkg::PH_KEY: begin
					key_we = 1'b1;
					if (key_idx_q == 2'd3) begin
						key_idx_d = 2'd0;
						if (remain_q == 16'd0) begin
							// empty text payload completes on the last key byte
							phase_d          = wsdf_pkg::PH_IDLE;
							emit             = 1'b1;
							res_d.frame_done = 1'b1;
							res_d.status     = wsdf_pkg::ST_OK;
						end else begin
							phase_d = wsdf_pkg::PH_DATA;
						end
					end else begin
						key_idx_d = key_idx_q + 2'd1;
					end
					if (!emit && beat_s1.frame_last) begin
						phase_d          = wsdf_pkg::PH_IDLE;
						emit             = 1'b1;
						res_d.frame_done = 1'b1;
						res_d.status     = trunc_st;
					end
				end
				wsdf_pkg::PH_DATA: begin
					key_idx_d        = key_idx_q + 2'd1;
					remain_d         = remain_dec;
					emit             = 1'b1;
					res_d.out_byte   = b ^ mask_key_q[key_idx_q];
					res_d.byte_valid = 1'b1;
					if (remain_dec == 16'd0) begin
						phase_d          = wsdf_pkg::PH_IDLE;
						res_d.frame_done = 1'b1;
						res_d.status     = wsdf_pkg::ST_OK;
					end else if (beat_s1.frame_last) begin
						phase_d          = wsdf_pkg::PH_IDLE;
						res_d.frame_done = 1'b1;
						res_d.status     = wsdf_pkg::ST_TRUNC;
					end
				end
				default: begin
					// idle: stray bytes outside a frame are dropped
					phase_d = wsdf_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!frm_stall) begin
			valid_s1 <= frm_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!frm_stall && frm_valid) begin
			beat_s1 <= frm;
		end
	end

	// parser state, updated as the beat leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wsdf_pkg::PH_IDLE;
			kind_q    <= wsdf_pkg::KIND_TEXT;
			len_hi_q  <= 8'd0;
			remain_q  <= 16'd0;
			key_idx_q <= 2'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			kind_q    <= kind_d;
			len_hi_q  <= len_hi_d;
			remain_q  <= remain_d;
			key_idx_q <= key_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && key_we) begin
			mask_key_q[key_idx_q] <= b;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

`ifndef ASSERT_OFF
	// a result without frame_done is always a plain payload byte
	a_mid_frame_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.frame_done |-> res_q.byte_valid && res_q.status == wsdf_pkg::ST_OK)
		else $error("non-final result is not a payload byte");

	// payload bytes only come out of the data phase of a text frame
	a_data_only_text: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && res_d.byte_valid |->
			phase_q == wsdf_pkg::PH_DATA && kind_q == wsdf_pkg::KIND_TEXT)
		else $error("payload byte outside text data phase");

	// a finished frame leaves the parser idle
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && res_d.frame_done |=> phase_q == wsdf_pkg::PH_IDLE)
		else $error("parser not idle after frame end");

	// input backpressure only while a beat is held in the input register
	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		frm_stall |-> valid_s1 && res_valid_q)
		else $error("input stalled with nothing held");
`endif

endmodule
